// ----- rtl/ksa_pkg.sv -----
`default_nettype none

package ksa_pkg;

    // Default sizing of the slot table and the stored key.
    localparam int DEF_MAX_SLOTS = 64;
    localparam int DEF_KEY_WIDTH = 64;

    // Operation codes carried in the request; code 3 has no meaning.
    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_LOOKUP  = 2'd2;

    // Request payload.
    typedef struct packed {
        logic [1:0]  op;
        logic [63:0] chunk_key;
    } req_t;

    // Result payload.
    typedef struct packed {
        logic       ok;
        logic [5:0] slot;
        logic       fresh;
    } rsp_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_TAIL,
        ST_DECIDE,
        ST_POP
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;
        logic load;
        logic scan;
        logic decide;
        logic pop;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic scan_last;
        logic need_pop;
    } stat_t;

endpackage

`default_nettype wire

// ----- rtl/ksa_ctrl.sv -----
`default_nettype none

module ksa_ctrl
    import ksa_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  start,
    input  wire logic  cfg_we,
    input  wire stat_t stat,
    output cmd_t       cmd,
    output logic       busy
);

    state_t state_reg;
    state_t state_next;

    // State register; reset starts a clearing pass over the key table.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = ST_TAIL;
                end
            end
            ST_TAIL:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = stat.need_pop ? ST_POP : ST_IDLE;
            end
            ST_POP:
            begin
                cmd.pop    = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase

        // A slot count write restarts the clearing pass.
        if (cfg_we)
        begin
            state_next = ST_CLEAR;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/ksa_datapath.sv -----
`default_nettype none

module ksa_datapath
    import ksa_pkg::*;
#(
    parameter int MAX_SLOTS = DEF_MAX_SLOTS,
    parameter int KEY_WIDTH = DEF_KEY_WIDTH
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [6:0] cfg_data,
    input  wire req_t       req,
    input  wire cmd_t       cmd,
    output stat_t           stat,
    output logic            done,
    output rsp_t            rsp
);

    localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W  = $clog2(MAX_SLOTS + 1);

    // Key table: valid bit over the key. Free stack of slot numbers.
    logic [KEY_WIDTH:0] key_mem [MAX_SLOTS];
    logic [SLOT_W-1:0]  stk_mem [MAX_SLOTS];

    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     top_reg, top_next;
    logic [CNT_W-1:0]     wm_reg, wm_next;
    logic [SLOT_W-1:0]    clr_addr_reg, clr_addr_next;
    logic [SLOT_W-1:0]    scan_addr_reg, scan_addr_next;
    logic                 rd_pend_reg, rd_pend_next;
    logic                 hit_reg, hit_next;
    logic                 done_reg, done_next;
    logic [1:0]           op_reg, op_next;
    logic [KEY_WIDTH-1:0] key_reg, key_next;
    logic [SLOT_W-1:0]    hit_slot_reg, hit_slot_next;
    logic [SLOT_W-1:0]    rd_addr_reg, rd_addr_next;
    rsp_t                 rsp_reg, rsp_next;
    logic [KEY_WIDTH:0]   km_rd_reg;
    logic [SLOT_W-1:0]    stk_rd_reg;

    logic                 km_we;
    logic [SLOT_W-1:0]    km_addr;
    logic [KEY_WIDTH:0]   km_wdata;
    logic                 push;
    logic [CNT_W-1:0]     cfg_cnt;
    logic [CNT_W-1:0]     orig_cnt;
    logic [SLOT_W-1:0]    pop_slot;
    logic                 op_known;
    logic                 match;

    // Index of the entry just below the given stack top.
    function automatic logic [SLOT_W-1:0] orig_top_idx(input logic [CNT_W-1:0] top);
        logic [CNT_W-1:0] idx;
        idx = top - CNT_W'(1);
        return idx[SLOT_W-1:0];
    endfunction

    // Requested slot count, saturated to the table size.
    assign cfg_cnt = (32'(cfg_data) > 32'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) : CNT_W'(cfg_data);

    // Stack entries below the low-water mark still hold their fill value.
    assign orig_cnt = count_reg - top_reg - CNT_W'(1);
    assign pop_slot = (top_reg < wm_reg) ? orig_cnt[SLOT_W-1:0] : stk_rd_reg;

    assign op_known = (op_reg == OP_ALLOC) || (op_reg == OP_RELEASE) || (op_reg == OP_LOOKUP);
    assign push     = cmd.decide && (op_reg == OP_RELEASE) && hit_reg
                      && (top_reg < CNT_W'(MAX_SLOTS));
    assign match    = rd_pend_reg && km_rd_reg[KEY_WIDTH]
                      && (km_rd_reg[KEY_WIDTH-1:0] == key_reg);

    // Status back to the controller.
    assign stat.clr_last  = (clr_addr_reg == SLOT_W'(MAX_SLOTS - 1));
    assign stat.scan_last = (scan_addr_reg == SLOT_W'(MAX_SLOTS - 1));
    assign stat.need_pop  = (op_reg == OP_ALLOC) && !hit_reg && (top_reg != '0);

    // Key table write port: clearing, unmapping on release, mapping on pop.
    always_comb
    begin
        km_we    = 1'b0;
        km_addr  = clr_addr_reg;
        km_wdata = '0;
        priority if (cmd.clear)
        begin
            km_we = 1'b1;
        end
        else if (cmd.decide && (op_reg == OP_RELEASE) && hit_reg)
        begin
            km_we   = 1'b1;
            km_addr = hit_slot_reg;
        end
        else if (cmd.pop)
        begin
            km_we    = 1'b1;
            km_addr  = pop_slot;
            km_wdata = {1'b1, key_reg};
        end
    end

    // Key table: one write, one registered read at the scan address.
    always_ff @(posedge clk)
    begin
        if (km_we)
        begin
            key_mem[km_addr] <= km_wdata;
        end
        km_rd_reg <= key_mem[scan_addr_reg];
    end

    // Free stack: push on release, read the top entry when deciding.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            stk_mem[top_reg[SLOT_W-1:0]] <= hit_slot_reg;
        end
        if (cmd.decide)
        begin
            stk_rd_reg <= stk_mem[orig_top_idx(top_reg)];
        end
    end

    // Next-state logic for counters, search and result.
    always_comb
    begin
        count_next     = count_reg;
        top_next       = top_reg;
        wm_next        = wm_reg;
        clr_addr_next  = clr_addr_reg;
        scan_addr_next = scan_addr_reg;
        rd_pend_next   = cmd.scan;
        rd_addr_next   = scan_addr_reg;
        hit_next       = hit_reg;
        hit_slot_next  = hit_slot_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        done_next      = 1'b0;
        rsp_next       = rsp_reg;

        // Clearing pass over the key table.
        if (cmd.clear)
        begin
            clr_addr_next = clr_addr_reg + SLOT_W'(1);
        end

        // Take in a request and start the search from slot 0.
        if (cmd.load)
        begin
            op_next        = req.op;
            key_next       = req.chunk_key[KEY_WIDTH-1:0];
            scan_addr_next = '0;
            hit_next       = 1'b0;
        end

        if (cmd.scan)
        begin
            scan_addr_next = scan_addr_reg + SLOT_W'(1);
        end

        // Compare the entry read in the previous cycle; first match wins.
        if (match && !hit_reg)
        begin
            hit_next      = 1'b1;
            hit_slot_next = rd_addr_reg;
        end

        // Search complete: answer, pushing a released slot back, or pop a slot for a new mapping.
        if (cmd.decide)
        begin
            if (stat.need_pop)
            begin
                top_next = top_reg - CNT_W'(1);
            end
            else
            begin
                done_next      = 1'b1;
                rsp_next.ok    = hit_reg && op_known;
                rsp_next.slot  = (hit_reg && op_known) ? 6'(hit_slot_reg) : 6'd0;
                rsp_next.fresh = 1'b0;
            end
            if (push)
            begin
                top_next = top_reg + CNT_W'(1);
                wm_next  = (top_reg < wm_reg) ? top_reg : wm_reg;
            end
        end

        if (cmd.pop)
        begin
            done_next      = 1'b1;
            rsp_next.ok    = 1'b1;
            rsp_next.slot  = 6'(pop_slot);
            rsp_next.fresh = 1'b1;
        end

        // A slot count write refills the stack and restarts the clear.
        if (cfg_we)
        begin
            count_next    = cfg_cnt;
            top_next      = cfg_cnt;
            wm_next       = cfg_cnt;
            clr_addr_next = '0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            top_reg       <= '0;
            wm_reg        <= '0;
            clr_addr_reg  <= '0;
            scan_addr_reg <= '0;
            rd_pend_reg   <= 1'b0;
            hit_reg       <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            top_reg       <= top_next;
            wm_reg        <= wm_next;
            clr_addr_reg  <= clr_addr_next;
            scan_addr_reg <= scan_addr_next;
            rd_pend_reg   <= rd_pend_next;
            hit_reg       <= hit_next;
            done_reg      <= done_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        key_reg      <= key_next;
        hit_slot_reg <= hit_slot_next;
        rd_addr_reg  <= rd_addr_next;
        rsp_reg      <= rsp_next;
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

`default_nettype wire

// ----- rtl/keyed_slot_allocator_top.sv -----
// A request is taken while busy is low; the linear search over the key table then reads
// every slot; the result is strobed when decided, or after an allocate pops a new slot.
// One request is worked at a time and no new one is taken while busy; the next request is taken
// in the cycle its predecessor's result is shown. The receiver cannot stall the result.
// Reset, and every slot_count write, run a clearing pass over every entry of the key
// table during which busy is high; after reset there are no slots.
`default_nettype none

module keyed_slot_allocator_top
    import ksa_pkg::*;
#(
    parameter int MAX_SLOTS = DEF_MAX_SLOTS,
    parameter int KEY_WIDTH = DEF_KEY_WIDTH
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [6:0] cfg_data,
    input  wire logic       start,
    output logic            busy,
    input  wire req_t       req,
    output logic            done,
    output rsp_t            rsp
);

    cmd_t  cmd;
    stat_t stat;

    // Sequencer.
    ksa_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cfg_we (cfg_we),
        .stat   (stat),
        .cmd    (cmd),
        .busy   (busy)
    );

    // Key table, free stack and result register.
    ksa_datapath #(
        .MAX_SLOTS (MAX_SLOTS),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .req      (req),
        .cmd      (cmd),
        .stat     (stat),
        .done     (done),
        .rsp      (rsp)
    );

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 100ps

module tb;
    import ksa_pkg::*;

    localparam int SLOT_LIMIT = DEF_MAX_SLOTS;
    localparam int IDLE_LIMIT = 3000;
    localparam int TAIL_CYCLES = 80;

    // Kinds of entry waiting in the driver's queue.
    typedef enum logic [1:0] {
        ITEM_REQUEST,
        ITEM_SLOT_COUNT,
        ITEM_DRAIN
    } item_kind_t;

    typedef struct {
        item_kind_t kind;
        req_t       req;
        logic [6:0] value;
    } pending_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic [6:0] cfg_data = '0;
    logic       start = 1'b0;
    logic       busy;
    req_t       req = '0;
    logic       done;
    rsp_t       rsp;

    keyed_slot_allocator_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .start    (start),
        .busy     (busy),
        .req      (req),
        .done     (done),
        .rsp      (rsp)
    );

    // Free-running clock, 8 ns period.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Shadow copy of the slot table and free stack.
    logic [63:0] shadow_key [SLOT_LIMIT];
    logic        shadow_valid [SLOT_LIMIT];
    logic [5:0]  shadow_free [SLOT_LIMIT];
    int          shadow_top = 0;

    pending_t pending_q [$];
    rsp_t     slot_answers_q [$];
    int       in_flight = 0;
    int       accepted_count = 0;
    int       gap_cycles = 0;
    int       mismatches = 0;
    int       idle_cycles = 0;
    int       request_total = 0;

    initial
    begin
        for (int i = 0; i < SLOT_LIMIT; i++)
        begin
            shadow_valid[i] = 1'b0;
            shadow_key[i] = '0;
            shadow_free[i] = '0;
        end
    end

    // A slot_count write clears every mapping and stacks the slots so that 0 pops first.
    function automatic void load_slot_count(logic [6:0] value);
        int n;
        n = (value > SLOT_LIMIT) ? SLOT_LIMIT : int'(value);
        for (int i = 0; i < SLOT_LIMIT; i++)
            shadow_valid[i] = 1'b0;
        for (int i = 0; i < n; i++)
            shadow_free[i] = 6'(n - 1 - i);
        shadow_top = n;
    endfunction

    // Works out the answer to one request and updates the shadow table.
    function automatic rsp_t allocate_answer(req_t r);
        rsp_t res;
        int   hit;
        int   s;
        res = '0;
        hit = SLOT_LIMIT;
        for (int i = 0; i < SLOT_LIMIT; i++)
            if (hit == SLOT_LIMIT && shadow_valid[i] && shadow_key[i] == r.chunk_key)
                hit = i;
        case (r.op)
            OP_ALLOC:
            begin
                if (hit < SLOT_LIMIT)
                begin
                    res.ok = 1'b1;
                    res.slot = 6'(hit);
                end
                else if (shadow_top > 0)
                begin
                    shadow_top--;
                    s = int'(shadow_free[shadow_top]);
                    shadow_key[s] = r.chunk_key;
                    shadow_valid[s] = 1'b1;
                    res.ok = 1'b1;
                    res.slot = 6'(s);
                    res.fresh = 1'b1;
                end
            end
            OP_RELEASE:
            begin
                if (hit < SLOT_LIMIT)
                begin
                    shadow_valid[hit] = 1'b0;
                    if (shadow_top < SLOT_LIMIT)
                    begin
                        shadow_free[shadow_top] = 6'(hit);
                        shadow_top++;
                    end
                    res.ok = 1'b1;
                    res.slot = 6'(hit);
                end
            end
            OP_LOOKUP:
            begin
                if (hit < SLOT_LIMIT)
                begin
                    res.ok = 1'b1;
                    res.slot = 6'(hit);
                end
            end
            default:
            begin
                res = '0;
            end
        endcase
        return res;
    endfunction

    function automatic void add_request(logic [1:0] op, logic [63:0] key);
        pending_t p;
        p.kind = ITEM_REQUEST;
        p.req.op = op;
        p.req.chunk_key = key;
        p.value = '0;
        pending_q.insert(pending_q.size(), p);
        request_total++;
    endfunction

    function automatic void add_slot_count(logic [6:0] value);
        pending_t p;
        p.kind = ITEM_SLOT_COUNT;
        p.req = '0;
        p.value = value;
        pending_q.insert(pending_q.size(), p);
    endfunction

    function automatic void add_drain();
        pending_t p;
        p.kind = ITEM_DRAIN;
        p.req = '0;
        p.value = '0;
        pending_q.insert(pending_q.size(), p);
    endfunction

    // Driver: presents requests, writes slot_count only when nothing is outstanding.
    always @(posedge clk)
    begin : driver
        logic     taken;
        logic     start_n;
        logic     we_n;
        logic     quiet;
        int       flight_n;
        pending_t head;
        if (rst_n)
        begin
            taken = start && !busy;
            start_n = start && busy;
            we_n = 1'b0;
            flight_n = in_flight + int'(taken) - int'(done);
            quiet = accepted_count >= 500 && accepted_count < 800;
            if (taken)
            begin
                slot_answers_q.insert(slot_answers_q.size(), allocate_answer(req));
                accepted_count <= accepted_count + 1;
                if (!quiet && $urandom_range(99) < 27)
                    gap_cycles = $urandom_range(90, 1);
            end
            // Nothing new goes out in the cycle a register write is being taken.
            if (!start_n && !cfg_we && pending_q.size() != 0)
            begin
                if (gap_cycles != 0)
                begin
                    gap_cycles--;
                end
                else
                begin
                    head = pending_q[0];
                    case (head.kind)
                        ITEM_REQUEST:
                        begin
                            start_n = 1'b1;
                            req <= head.req;
                            void'(pending_q.pop_front());
                        end
                        ITEM_SLOT_COUNT:
                        begin
                            if (flight_n == 0 && !busy)
                            begin
                                we_n = 1'b1;
                                cfg_data <= head.value;
                                load_slot_count(head.value);
                                void'(pending_q.pop_front());
                            end
                        end
                        default:
                        begin
                            if (flight_n == 0)
                                void'(pending_q.pop_front());
                        end
                    endcase
                end
            end
            start <= start_n;
            cfg_we <= we_n;
            in_flight <= flight_n;
        end
    end

    // Monitor: every strobed result is checked against the oldest expected answer.
    always @(posedge clk)
    begin : monitor
        rsp_t want;
        if (rst_n && done)
        begin
            if (slot_answers_q.size() == 0)
            begin
                $error("result with no request outstanding: ok=%0d slot=%0d fresh=%0d",
                       rsp.ok, rsp.slot, rsp.fresh);
                mismatches++;
            end
            else
            begin
                want = slot_answers_q.pop_front();
                if (rsp.ok !== want.ok)
                begin
                    $error("ok: expected %0d, got %0d", want.ok, rsp.ok);
                    mismatches++;
                end
                if (rsp.slot !== want.slot)
                begin
                    $error("slot: expected %0d, got %0d", want.slot, rsp.slot);
                    mismatches++;
                end
                if (rsp.fresh !== want.fresh)
                begin
                    $error("fresh: expected %0d, got %0d", want.fresh, rsp.fresh);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog on cycles in which nothing moves.
    always @(posedge clk)
    begin : watchdog
        if (rst_n)
        begin
            if ((start && !busy) || done || cfg_we)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Stimulus and end of run.
    initial
    begin : stimulus
        logic [63:0] key_pool [$];
        logic [63:0] key;
        int          pick;
        int          count;
        int          usable;
        int          pool_size;
        int          run_length;
        logic        drained;
        logic        leftover;
        drained = 1'b0;
        leftover = 1'b0;

        // Directed: no slots straight after reset, so allocate must fail.
        add_request(OP_ALLOC, 64'h0);
        add_request(OP_LOOKUP, 64'h0);
        add_slot_count(7'd4);
        add_request(OP_LOOKUP, 64'h0);
        add_request(OP_RELEASE, 64'hFFFF_FFFF_FFFF_FFFF);
        add_request(OP_ALLOC, 64'h0);
        add_request(OP_ALLOC, 64'hFFFF_FFFF_FFFF_FFFF);
        add_request(OP_ALLOC, 64'h0);
        add_request(OP_ALLOC, 64'h8000_0000_0000_0000);
        add_request(OP_ALLOC, 64'h0000_0000_0000_0001);
        // The stack is empty now.
        add_request(OP_ALLOC, 64'h5555_AAAA_5555_AAAA);
        add_request(OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF);
        add_request(OP_RELEASE, 64'h0);
        add_request(OP_RELEASE, 64'h0);
        add_request(OP_ALLOC, 64'h5555_AAAA_5555_AAAA);
        add_request(2'd3, 64'h5555_AAAA_5555_AAAA);
        add_request(OP_LOOKUP, 64'h5555_AAAA_5555_AAAA);
        // Oversized count saturates to the full table.
        add_slot_count(7'd127);
        add_request(OP_LOOKUP, 64'h5555_AAAA_5555_AAAA);
        add_request(OP_ALLOC, 64'hAAAA_5555_AAAA_5555);
        add_slot_count(7'd0);
        add_request(OP_ALLOC, 64'h1234_5678_9ABC_DEF0);
        add_request(OP_RELEASE, 64'h1234_5678_9ABC_DEF0);
        add_slot_count(7'd64);
        add_request(OP_ALLOC, 64'h1234_5678_9ABC_DEF0);
        add_slot_count(7'd1);
        add_request(OP_ALLOC, 64'h1);
        add_request(OP_ALLOC, 64'h2);

        // Random phases: each picks a slot count and works a small key pool against it.
        while (request_total < 1500)
        begin
            pick = $urandom_range(99);
            if (pick < 5)
                count = 0;
            else if (pick < 15)
                count = 64;
            else if (pick < 22)
                count = $urandom_range(127, 65);
            else
                count = $urandom_range(12, 1);
            if (!drained && request_total > 700)
            begin
                add_drain();
                drained = 1'b1;
            end
            add_slot_count(7'(count));
            usable = (count > SLOT_LIMIT) ? SLOT_LIMIT : count;
            pool_size = usable + usable / 2 + 2;
            key_pool.delete();
            for (int i = 0; i < pool_size; i++)
                key_pool.insert(key_pool.size(), {$urandom, $urandom});
            run_length = 2 * usable + $urandom_range(60, 20);
            for (int j = 0; j < run_length; j++)
            begin
                pick = $urandom_range(99);
                key = key_pool[$urandom_range(pool_size - 1)];
                // Near misses differ from a pool key in one bit only.
                if (pick < 5)
                    key[$urandom_range(63)] ^= 1'b1;
                else if (pick < 12)
                    key = {$urandom, $urandom};
                pick = $urandom_range(99);
                if (pick < 45)
                    add_request(OP_ALLOC, key);
                else if (pick < 70)
                    add_request(OP_RELEASE, key);
                else if (pick < 95)
                    add_request(OP_LOOKUP, key);
                else
                    add_request(2'd3, key);
            end
        end

        // Reset once, then let the driver run the queue dry.
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        // Sampled between edges so the driver's updates for the edge are settled.
        do
            @(negedge clk);
        while (pending_q.size() != 0 || in_flight != 0 || start);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (slot_answers_q.size() != 0)
        begin
            $error("%0d results never arrived", slot_answers_q.size());
            leftover = 1'b1;
        end
        if (mismatches == 0 && !leftover)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- keyed_slot_allocator_top.f -----
rtl/ksa_pkg.sv
rtl/ksa_ctrl.sv
rtl/ksa_datapath.sv
rtl/keyed_slot_allocator_top.sv
tb/tb.sv
